// ----- rtl/core/bcc_pkg.sv -----
// Shared types and constants for the 2-D barycentric coordinate pipeline.
// No dependencies; every other file in rtl/core refers to this package.
package bcc_pkg;

  localparam int FIELD_W  = 24;   // input coordinate width
  localparam int DIFF_W   = 25;   // edge vector component
  localparam int DOT_W    = 50;   // one component product
  localparam int GRAM_W   = 51;   // Gram dot product, signed
  localparam int HALF_W   = 25;   // half of a Gram magnitude
  localparam int MAG_W    = 50;   // Gram magnitude
  localparam int PROD_W   = 101;  // signed product of two Gram terms
  localparam int NUM_W    = 102;  // numerator / determinant, signed
  localparam int WT_W     = 32;   // output weight
  localparam int QUO_W    = 33;   // quotient bits kept by the divider

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int GRAM_LAT = 3;
  localparam int MUL_LAT  = 4;
  localparam int DIV_LAT  = 3 + QUO_W + 1;
  localparam int PIPE_LAT = GRAM_LAT + MUL_LAT + 1 + DIV_LAT + 1;

  localparam logic signed [WT_W-1:0] WT_MAX = {1'b0, {(WT_W-1){1'b1}}};
  localparam logic signed [WT_W-1:0] WT_MIN = {1'b1, {(WT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_W-1:0] corner0_x;
    logic signed [FIELD_W-1:0] corner0_y;
    logic signed [FIELD_W-1:0] corner1_x;
    logic signed [FIELD_W-1:0] corner1_y;
    logic signed [FIELD_W-1:0] corner2_x;
    logic signed [FIELD_W-1:0] corner2_y;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } tri_t;

  typedef struct packed {
    logic signed [GRAM_W-1:0] m00;
    logic signed [GRAM_W-1:0] m01;
    logic signed [GRAM_W-1:0] m11;
    logic signed [GRAM_W-1:0] r0;
    logic signed [GRAM_W-1:0] r1;
  } gram_t;

  typedef struct packed {
    logic signed [WT_W-1:0] u_coord;
    logic signed [WT_W-1:0] v_coord;
    logic signed [WT_W-1:0] w_coord;
    logic                   degenerate;
  } res_t;

endpackage

// ----- rtl/core/bcc_in_if.sv -----
// Request channel carrying one triangle and one query point.
// Depends on bcc_pkg for field widths.
interface bcc_in_if;
  logic valid;
  logic ready;
  logic signed [bcc_pkg::FIELD_W-1:0] corner0_x;
  logic signed [bcc_pkg::FIELD_W-1:0] corner0_y;
  logic signed [bcc_pkg::FIELD_W-1:0] corner1_x;
  logic signed [bcc_pkg::FIELD_W-1:0] corner1_y;
  logic signed [bcc_pkg::FIELD_W-1:0] corner2_x;
  logic signed [bcc_pkg::FIELD_W-1:0] corner2_y;
  logic signed [bcc_pkg::FIELD_W-1:0] point_x;
  logic signed [bcc_pkg::FIELD_W-1:0] point_y;

  modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                  corner2_x, corner2_y, point_x, point_y, input ready);
  modport sink (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                corner2_x, corner2_y, point_x, point_y, output ready);
endinterface

// ----- rtl/core/bcc_out_if.sv -----
// Result channel carrying the three weights and the degenerate flag.
// Depends on bcc_pkg for field widths.
interface bcc_out_if;
  logic valid;
  logic ready;
  logic signed [bcc_pkg::WT_W-1:0] u_coord;
  logic signed [bcc_pkg::WT_W-1:0] v_coord;
  logic signed [bcc_pkg::WT_W-1:0] w_coord;
  logic degenerate;

  modport source (output valid, u_coord, v_coord, w_coord, degenerate, input ready);
  modport sink (input valid, u_coord, v_coord, w_coord, degenerate, output ready);
endinterface

// ----- rtl/core/bcc_gram.sv -----
// Edge vectors and Gram dot products: differences, products, sums (3 stages).
// Depends on bcc_pkg.
module bcc_gram (
  input  logic           clk,
  input  logic           en,
  input  bcc_pkg::tri_t  tri_in,
  output bcc_pkg::gram_t gram
);
  localparam int DW = bcc_pkg::DIFF_W;
  localparam int PW = bcc_pkg::DOT_W;
  localparam int GW = bcc_pkg::GRAM_W;

  logic signed [DW-1:0] e0x, e0y, e1x, e1y, qx, qy;
  logic signed [PW-1:0] p00x, p00y, p01x, p01y, p11x, p11y, p0qx, p0qy, p1qx, p1qy;

  // form edge vectors relative to corner 2
  always_ff @(posedge clk) begin
    if (en) begin
      e0x <= DW'(tri_in.corner0_x) - DW'(tri_in.corner2_x);
      e0y <= DW'(tri_in.corner0_y) - DW'(tri_in.corner2_y);
      e1x <= DW'(tri_in.corner1_x) - DW'(tri_in.corner2_x);
      e1y <= DW'(tri_in.corner1_y) - DW'(tri_in.corner2_y);
      qx  <= DW'(tri_in.point_x) - DW'(tri_in.corner2_x);
      qy  <= DW'(tri_in.point_y) - DW'(tri_in.corner2_y);
    end
  end

  // component products
  always_ff @(posedge clk) begin
    if (en) begin
      p00x <= e0x * e0x;
      p00y <= e0y * e0y;
      p01x <= e0x * e1x;
      p01y <= e0y * e1y;
      p11x <= e1x * e1x;
      p11y <= e1y * e1y;
      p0qx <= e0x * qx;
      p0qy <= e0y * qy;
      p1qx <= e1x * qx;
      p1qy <= e1y * qy;
    end
  end

  // dot product sums
  always_ff @(posedge clk) begin
    if (en) begin
      gram.m00 <= GW'(p00x) + GW'(p00y);
      gram.m01 <= GW'(p01x) + GW'(p01y);
      gram.m11 <= GW'(p11x) + GW'(p11y);
      gram.r0  <= GW'(p0qx) + GW'(p0qy);
      gram.r1  <= GW'(p1qx) + GW'(p1qy);
    end
  end
endmodule

// ----- rtl/core/bcc_wmul.sv -----
// Exact signed product of two Gram terms from four 25x25 partial products.
// Four stages: magnitude, partials, combine, sign. Depends on bcc_pkg.
module bcc_wmul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [bcc_pkg::GRAM_W-1:0]  a,
  input  logic signed [bcc_pkg::GRAM_W-1:0]  b,
  output logic signed [bcc_pkg::PROD_W-1:0]  prod
);
  localparam int MW = bcc_pkg::MAG_W;
  localparam int HW = bcc_pkg::HALF_W;
  localparam int XW = 2 * MW;

  logic [MW-1:0] ma, mb;
  logic          neg1, neg2, neg3;
  logic [2*HW-1:0] pp0, pp1, pp2, pp3;
  logic [XW-1:0] mag;
  logic signed [XW:0] mx;

  // take magnitudes and the product sign
  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= a[bcc_pkg::GRAM_W-1] ? MW'(-a) : MW'(a);
      mb   <= b[bcc_pkg::GRAM_W-1] ? MW'(-b) : MW'(b);
      neg1 <= a[bcc_pkg::GRAM_W-1] ^ b[bcc_pkg::GRAM_W-1];
    end
  end

  // partial products of the halves
  always_ff @(posedge clk) begin
    if (en) begin
      pp0  <= ma[HW-1:0] * mb[HW-1:0];
      pp1  <= ma[HW-1:0] * mb[MW-1:HW];
      pp2  <= ma[MW-1:HW] * mb[HW-1:0];
      pp3  <= ma[MW-1:HW] * mb[MW-1:HW];
      neg2 <= neg1;
    end
  end

  // combine partials into the full magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= {pp3, pp0} + (XW'(pp1) << HW) + (XW'(pp2) << HW);
      neg3 <= neg2;
    end
  end

  assign mx = {1'b0, mag};

  // apply sign
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= neg3 ? -mx : mx;
    end
  end
endmodule

// ----- rtl/core/bcc_div.sv -----
// Pipelined restoring divider: round(num * 2^F / det), ties away from zero,
// saturated to 32 bits. One quotient bit per stage. Depends on bcc_pkg.
module bcc_div #(
  parameter int COORD_FRAC_BITS = bcc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [bcc_pkg::NUM_W-1:0]  num,
  input  logic signed [bcc_pkg::NUM_W-1:0]  det,
  output logic signed [bcc_pkg::WT_W-1:0]   weight
);
  localparam int MW  = bcc_pkg::NUM_W - 1;
  localparam int QB  = bcc_pkg::QUO_W;
  localparam int NW  = MW + COORD_FRAC_BITS + 2;
  localparam int DSW = MW + 1 + QB;
  localparam int RW  = (NW > DSW) ? NW : DSW;
  localparam int OW  = bcc_pkg::WT_W;

  logic [MW-1:0] mag1, det1;
  logic          neg1, neg2;
  logic [RW-1:0] n2, d2;

  logic [RW-1:0] rem [QB+1];
  logic [RW-1:0] dd  [QB+1];
  logic [QB-1:0] quo [QB+1];
  logic          neg [QB+1];
  logic          ovf [QB+1];

  logic [QB-1:0] qf;
  logic          sat_pos, sat_neg;
  logic [QB-1:0] qneg;

  // split sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= num[bcc_pkg::NUM_W-1];
      mag1 <= num[bcc_pkg::NUM_W-1] ? MW'(-num) : MW'(num);
      det1 <= MW'(det);
    end
  end

  // scaled dividend with half a divisor added for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      n2   <= (RW'(mag1) << (COORD_FRAC_BITS + 1)) + RW'(det1);
      d2   <= RW'(det1) << 1;
      neg2 <= neg1;
    end
  end

  // flag quotients too large for the kept bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n2;
      dd[0]  <= d2;
      quo[0] <= '0;
      neg[0] <= neg2;
      ovf[0] <= n2 >= (d2 << QB);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = dd[i] << (QB - 1 - i);
    assign ge  = rem[i] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? rem[i] - dsh : rem[i];
        dd[i+1]  <= dd[i];
        quo[i+1] <= {quo[i][QB-2:0], ge};
        neg[i+1] <= neg[i];
        ovf[i+1] <= ovf[i];
      end
    end
  end

  assign qf      = quo[QB];
  assign qneg    = -qf;
  assign sat_pos = ovf[QB] || qf[QB-1] || qf[QB-2];
  assign sat_neg = ovf[QB] || qf[QB-1] || (qf[QB-2] && (|qf[QB-3:0]));

  // apply sign and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[QB]) begin
        weight <= sat_neg ? bcc_pkg::WT_MIN : qneg[OW-1:0];
      end else begin
        weight <= sat_pos ? bcc_pkg::WT_MAX : qf[OW-1:0];
      end
    end
  end
endmodule

// ----- rtl/core/barycentric_coords_2d.sv -----
// Barycentric weights of a 2-D point in a triangle, fully pipelined.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if, bcc_gram, bcc_wmul, bcc_div.
//
//   channel   dir  payload                                  handshake
//   pts       in   corner0..2 x/y, point x/y (Q8.16)        valid/ready
//   weights   out  u/v/w_coord (Q16.16), degenerate         valid/ready
//
// One request enters per cycle unless the pipeline holds; a result passes
// through 46 pipeline stages plus the output register. The divider, one
// quotient bit per stage, makes up most of those stages.
// Reset clears the valid bits of the pipeline, the output register and the skid stage.
// A stalled output fills the skid stage, then the whole pipeline holds.
module barycentric_coords_2d #(
  parameter int COORD_FRAC_BITS = bcc_pkg::COORD_FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  bcc_in_if.sink   pts,
  bcc_out_if.source weights
);
  localparam int NW = bcc_pkg::NUM_W;
  localparam int PL = bcc_pkg::PIPE_LAT;
  localparam int DL = bcc_pkg::DIV_LAT;
  localparam int SW = bcc_pkg::WT_W + 2;

  logic en, acc;
  bcc_pkg::tri_t  tri_in;
  bcc_pkg::gram_t gram;
  logic signed [bcc_pkg::PROD_W-1:0] p_m00m11, p_m01m01, p_m11r0, p_m01r1;
  logic signed [bcc_pkg::PROD_W-1:0] p_m00r1, p_m01r0;
  logic signed [NW-1:0] det, num_u, num_v;
  logic signed [bcc_pkg::WT_W-1:0] u_w, v_w;
  logic [PL-1:0] vld;
  logic [DL-1:0] degen_d;
  logic signed [SW-1:0] wsum;
  bcc_pkg::res_t pd, od, sd;
  logic ov, sv;

  assign en        = !sv;
  assign pts.ready = en;
  assign acc       = pts.valid && en;

  assign tri_in = '{corner0_x: pts.corner0_x, corner0_y: pts.corner0_y,
                    corner1_x: pts.corner1_x, corner1_y: pts.corner1_y,
                    corner2_x: pts.corner2_x, corner2_y: pts.corner2_y,
                    point_x: pts.point_x, point_y: pts.point_y};

  bcc_gram u_gram (.clk, .en, .tri_in, .gram);

  bcc_wmul u_mul0 (.clk, .en, .a(gram.m00), .b(gram.m11), .prod(p_m00m11));
  bcc_wmul u_mul1 (.clk, .en, .a(gram.m01), .b(gram.m01), .prod(p_m01m01));
  bcc_wmul u_mul2 (.clk, .en, .a(gram.m11), .b(gram.r0),  .prod(p_m11r0));
  bcc_wmul u_mul3 (.clk, .en, .a(gram.m01), .b(gram.r1),  .prod(p_m01r1));
  bcc_wmul u_mul4 (.clk, .en, .a(gram.m00), .b(gram.r1),  .prod(p_m00r1));
  bcc_wmul u_mul5 (.clk, .en, .a(gram.m01), .b(gram.r0),  .prod(p_m01r0));

  // determinant and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      det   <= NW'(p_m00m11) - NW'(p_m01m01);
      num_u <= NW'(p_m11r0) - NW'(p_m01r1);
      num_v <= NW'(p_m00r1) - NW'(p_m01r0);
    end
  end

  bcc_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_u (
    .clk, .en, .num(num_u), .det, .weight(u_w));
  bcc_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_v (
    .clk, .en, .num(num_v), .det, .weight(v_w));

  // carry the degenerate flag alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      degen_d <= {degen_d[DL-2:0], det == '0};
    end
  end

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PL-2:0], acc};
    end
  end

  assign wsum = (SW'(1) <<< COORD_FRAC_BITS) - SW'(u_w) - SW'(v_w);

  // third weight, saturation, and zeroing for a flat triangle
  always_ff @(posedge clk) begin
    if (en) begin
      pd.degenerate <= degen_d[DL-1];
      if (degen_d[DL-1]) begin
        pd.u_coord <= '0;
        pd.v_coord <= '0;
        pd.w_coord <= '0;
      end else begin
        pd.u_coord <= u_w;
        pd.v_coord <= v_w;
        if (wsum > SW'(bcc_pkg::WT_MAX)) begin
          pd.w_coord <= bcc_pkg::WT_MAX;
        end else if (wsum < SW'(bcc_pkg::WT_MIN)) begin
          pd.w_coord <= bcc_pkg::WT_MIN;
        end else begin
          pd.w_coord <= wsum[bcc_pkg::WT_W-1:0];
        end
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || weights.ready) begin
      ov <= sv || (en && vld[PL-1]);
      sv <= 1'b0;
    end else if (en && vld[PL-1]) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || weights.ready) begin
      od <= sv ? sd : pd;
    end else if (en && vld[PL-1]) begin
      sd <= pd;
    end
  end

  assign weights.valid      = ov;
  assign weights.u_coord    = od.u_coord;
  assign weights.v_coord    = od.v_coord;
  assign weights.w_coord    = od.w_coord;
  assign weights.degenerate = od.degenerate;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov) else $error("skid stage full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !weights.ready))
    else $error("skid stage filled without an output stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (ov && od.degenerate) |-> (od.u_coord == '0 && od.v_coord == '0 && od.w_coord == '0))
    else $error("degenerate result carries nonzero weights");
endmodule
